>>> design/ctc_pkg.sv
package ctc_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int MAX_RESULTS  = 48;
    localparam int KEY_MAX      = 16;
    localparam int SYM_W        = 16;
    localparam int KEY_W        = 5;
    localparam int IDX_W        = $clog2(MAX_RESULTS);
    localparam int ACC_W        = IDX_W + 1;

    localparam logic [SYM_W-1:0] PAD_SYMBOL   = 16'h0020;
    localparam logic [SYM_W-1:0] CASE_OFFSET  = 16'h0020;
    localparam logic [SYM_W-1:0] UPPER_FIRST  = 16'h0041;
    localparam logic [SYM_W-1:0] UPPER_LAST   = 16'h005A;
    localparam logic [SYM_W-1:0] LOWER_FIRST  = 16'h0061;
    localparam logic [SYM_W-1:0] LOWER_LAST   = 16'h007A;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_KEY      = 3'd1,
        ST_KEY_LONG     = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_OVERFLOW     = 3'd4,
        ST_NOT_MULTIPLE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_EMIT
    } state_t;

    typedef enum logic {
        CFG_KEY_COLUMNS = 1'b0,
        CFG_DECODE_MODE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    div_init;
        logic    div_step;
        logic    emit_init;
        logic    issue;
        logic    err_load;
        status_t err_code;
    } cmd_t;

    typedef struct packed {
        status_t chk_err;
        logic    div_done;
        status_t div_err;
        logic    issue_last;
    } sts_t;

endpackage

>>> design/ctc_datapath.sv
module ctc_datapath
    import ctc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SYM_W-1:0] symbol,
    input  logic             cfg_valid,
    input  logic             cfg_index,
    input  logic [KEY_W-1:0] cfg_data,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic             strobe,
    output logic [SYM_W-1:0] out_symbol,
    output logic             last_out,
    output logic [2:0]       status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [SYM_W-1:0] mem [CAPACITY];

    logic [KEY_W-1:0] key_reg;
    logic             mode_reg;
    logic [CW-1:0]    n_reg, n_next;
    logic             ovf_reg, ovf_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CW-1:0]    h_reg, h_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] o_reg, o_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             emit_vld_reg;
    logic             pad_reg;
    logic             lastf_reg;
    logic             err_vld_reg;
    status_t          err_code_reg;
    logic [SYM_W-1:0] rdata_reg;

    logic             is_upper;
    logic             is_lower;
    logic             keep;
    logic             full;
    logic             do_write;
    logic [SYM_W-1:0] sym_f;
    logic [ACC_W-1:0] n_ext;
    logic [ACC_W-1:0] k_ext;
    logic [IDX_W-1:0] k_idx;
    logic [IDX_W-1:0] h_idx;
    logic [IDX_W-1:0] inner_lim;
    logic [IDX_W-1:0] outer_lim;
    logic [IDX_W-1:0] step;
    logic             inner_end;
    logic             pad;
    status_t          chk_err;
    status_t          div_err;
    logic             div_done;
    logic             issue_last;

    assign is_upper = (symbol >= UPPER_FIRST) && (symbol <= UPPER_LAST);
    assign is_lower = (symbol >= LOWER_FIRST) && (symbol <= LOWER_LAST);
    assign keep     = mode_reg || is_upper || is_lower;
    assign sym_f    = (!mode_reg && is_lower) ? (symbol - CASE_OFFSET) : symbol;
    assign full     = (n_reg >= CW'(CAPACITY));
    assign do_write = cmd.load && keep && !full;

    assign n_ext = ACC_W'(n_reg);
    assign k_ext = ACC_W'(key_reg);
    assign k_idx = IDX_W'(key_reg);
    assign h_idx = IDX_W'(h_reg);

    always_comb
    begin
        if (ovf_reg)
        begin
            chk_err = ST_OVERFLOW;
        end
        else if (n_reg == '0)
        begin
            chk_err = ST_EMPTY;
        end
        else if ((key_reg == '0) || (key_reg > KEY_W'(KEY_MAX)))
        begin
            chk_err = ST_BAD_KEY;
        end
        else if (k_ext > (n_ext >> 1))
        begin
            chk_err = ST_KEY_LONG;
        end
        else
        begin
            chk_err = ST_OK;
        end
    end

    assign div_done = (acc_reg >= n_ext);

    always_comb
    begin
        if (mode_reg)
        begin
            div_err = (acc_reg != n_ext) ? ST_NOT_MULTIPLE : ST_OK;
        end
        else
        begin
            div_err = (acc_reg > ACC_W'(MAX_RESULTS)) ? ST_OVERFLOW : ST_OK;
        end
    end

    assign inner_lim = mode_reg ? k_idx : h_idx;
    assign outer_lim = mode_reg ? h_idx : k_idx;
    assign step      = mode_reg ? h_idx : k_idx;
    assign inner_end = (i_reg == inner_lim - 1'b1);
    assign pad       = (idx_reg >= IDX_W'(n_reg));

    assign issue_last = inner_end && (o_reg == outer_lim - 1'b1);

    assign sts = '{chk_err: chk_err, div_done: div_done, div_err: div_err,
                   issue_last: issue_last};

    always_comb
    begin
        n_next   = n_reg;
        ovf_next = ovf_reg;
        if (cmd.clear)
        begin
            n_next   = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.load && keep)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                n_next = n_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        h_next   = h_reg;
        if (cmd.div_init)
        begin
            acc_next = '0;
            h_next   = '0;
        end
        else if (cmd.div_step)
        begin
            acc_next = acc_reg + k_ext;
            h_next   = h_reg + 1'b1;
        end
    end

    always_comb
    begin
        i_next   = i_reg;
        o_next   = o_reg;
        idx_next = idx_reg;
        if (cmd.emit_init)
        begin
            i_next   = '0;
            o_next   = '0;
            idx_next = '0;
        end
        else if (cmd.issue)
        begin
            if (inner_end)
            begin
                i_next   = '0;
                o_next   = o_reg + 1'b1;
                idx_next = o_reg + 1'b1;
            end
            else
            begin
                i_next   = i_reg + 1'b1;
                idx_next = idx_reg + step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= KEY_W'(1);
            mode_reg     <= 1'b0;
            n_reg        <= '0;
            ovf_reg      <= 1'b0;
            emit_vld_reg <= 1'b0;
            err_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_KEY_COLUMNS: key_reg  <= cfg_data;
                    CFG_DECODE_MODE: mode_reg <= cfg_data[0];
                    default:         key_reg  <= key_reg;
                endcase
            end
            n_reg        <= n_next;
            ovf_reg      <= ovf_next;
            emit_vld_reg <= cmd.issue;
            err_vld_reg  <= cmd.err_load;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        h_reg   <= h_next;
        i_reg   <= i_next;
        o_reg   <= o_next;
        idx_reg <= idx_next;
        if (cmd.issue)
        begin
            pad_reg   <= pad;
            lastf_reg <= issue_last;
        end
        if (cmd.err_load)
        begin
            err_code_reg <= cmd.err_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[n_reg[AW-1:0]] <= sym_f;
        end
        if (cmd.issue && !pad)
        begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        strobe = emit_vld_reg || err_vld_reg;
        if (err_vld_reg)
        begin
            out_symbol = '0;
            last_out   = 1'b1;
            status     = err_code_reg;
        end
        else
        begin
            out_symbol = pad_reg ? PAD_SYMBOL : rdata_reg;
            last_out   = lastf_reg && emit_vld_reg;
            status     = ST_OK;
        end
    end

endmodule

>>> design/ctc_ctrl.sv
module ctc_ctrl
    import ctc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic last_in,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && last_in)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (sts.chk_err != ST_OK) ? S_IDLE : S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    state_next = (sts.div_err != ST_OK) ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.issue_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_CHECK:
            begin
                if (sts.chk_err != ST_OK)
                begin
                    cmd.err_load = 1'b1;
                    cmd.err_code = sts.chk_err;
                    cmd.clear    = 1'b1;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                end
            end
            S_DIVIDE:
            begin
                if (!sts.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (sts.div_err != ST_OK)
                begin
                    cmd.err_load = 1'b1;
                    cmd.err_code = sts.div_err;
                    cmd.clear    = 1'b1;
                end
                else
                begin
                    cmd.emit_init = 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.issue = 1'b1;
                cmd.clear = sts.issue_last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/columnar_transposition_cipher.sv
// Symbols are taken one per cycle while busy is low; the transaction carrying last_in starts
// the transposition. Busy then stays high through a check step, a divide step in which the
// grid height ceil(length / key_columns) is found by repeated addition of the key, and an
// emit step that reads one grid symbol at a time, as the text memory has a single read port.
// Results leave at one per cycle, each for exactly one cycle under strobe, and the receiver
// cannot stall them: it must take every strobed result as it comes. An error gives a single
// result with last_out set and a nonzero status. The next message may start as soon as busy
// falls, while the final result is still on the ports. The configuration port is always ready
// and is to be written only while busy is low and no results are outstanding.
module columnar_transposition_cipher
    import ctc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [SYM_W-1:0] symbol,
    input  logic             last_in,
    output logic             strobe,
    output logic [SYM_W-1:0] out_symbol,
    output logic             last_out,
    output logic [2:0]       status,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [KEY_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ctc_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .last_in (last_in),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    ctc_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol     (symbol),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .strobe     (strobe),
        .out_symbol (out_symbol),
        .last_out   (last_out),
        .status     (status)
    );

endmodule

>>> verif/testbench.sv
module testbench
    import ctc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        status_t          st;
    } cipher_out_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [SYM_W-1:0] symbol;
    logic             last_in;
    logic             strobe;
    logic [SYM_W-1:0] out_symbol;
    logic             last_out;
    logic [2:0]       status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [KEY_W-1:0] cfg_data;

    logic [SYM_W-1:0] text_copy [DEF_CAPACITY];
    int               text_len;
    bit               text_overflow;
    logic [KEY_W-1:0] key_setting;
    logic             decode_setting;

    cipher_out_t      pending_cipher_out[$];
    int               mismatch_count;
    int               symbols_kept;
    int               items_sent;
    int               messages_sent;
    int               results_checked;
    int               burst_left;

    columnar_transposition_cipher DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .symbol     (symbol),
        .last_in    (last_in),
        .strobe     (strobe),
        .out_symbol (out_symbol),
        .last_out   (last_out),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic queue_result(input cipher_out_t r);
        pending_cipher_out.insert(pending_cipher_out.size(), r);
    endtask

    task automatic push_error(input status_t code);
        cipher_out_t r;
        r.sym  = '0;
        r.last = 1'b1;
        r.st   = code;
        queue_result(r);
    endtask

    task automatic transpose_message();
        int          n;
        int          k;
        int          h;
        int          idx;
        int          total;
        int          cnt;
        cipher_out_t r;
        n = text_len;
        k = key_setting;
        cnt = 0;
        if (text_overflow)
            push_error(ST_OVERFLOW);
        else if (n == 0)
            push_error(ST_EMPTY);
        else if (k == 0 || k > KEY_MAX)
            push_error(ST_BAD_KEY);
        else if (k > n / 2)
            push_error(ST_KEY_LONG);
        else if (decode_setting && (n % k) != 0)
            push_error(ST_NOT_MULTIPLE);
        else if (decode_setting)
        begin
            h = n / k;
            for (int row = 0; row < h; row++)
                for (int col = 0; col < k; col++)
                begin
                    idx    = col * h + row;
                    r.sym  = text_copy[idx];
                    r.last = (cnt == n - 1);
                    r.st   = ST_OK;
                    queue_result(r);
                    cnt++;
                end
        end
        else
        begin
            h = (n + k - 1) / k;
            total = h * k;
            if (total > MAX_RESULTS)
                push_error(ST_OVERFLOW);
            else
                for (int col = 0; col < k; col++)
                    for (int row = 0; row < h; row++)
                    begin
                        idx    = row * k + col;
                        r.sym  = (idx < n) ? text_copy[idx] : PAD_SYMBOL;
                        r.last = (cnt == total - 1);
                        r.st   = ST_OK;
                        queue_result(r);
                        cnt++;
                    end
        end
        text_len = 0;
        text_overflow = 0;
    endtask

    task automatic absorb_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
        logic [SYM_W-1:0] s;
        bit               keep;
        s = sym;
        keep = 1;
        items_sent++;
        if (!decode_setting)
        begin
            if (s >= LOWER_FIRST && s <= LOWER_LAST)
                s = s - CASE_OFFSET;
            else if (!(s >= UPPER_FIRST && s <= UPPER_LAST))
                keep = 0;
        end
        if (keep)
        begin
            symbols_kept++;
            if (text_len < DEF_CAPACITY)
            begin
                text_copy[text_len] = s;
                text_len++;
            end
            else
                text_overflow = 1;
        end
        if (is_last)
        begin
            messages_sent++;
            transpose_message();
        end
    endtask

    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_cipher_out.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result symbol=%h last=%b status=%0d",
                             $realtime, out_symbol, last_out, status);
            end
            else
            begin
                want = pending_cipher_out.pop_front();
                results_checked++;
                if (out_symbol !== want.sym || last_out !== want.last
                    || status !== want.st)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected symbol=%h last=%b status=%0d, got %h %b %0d",
                                 $realtime, want.sym, want.last, want.st,
                                 out_symbol, last_out, status);
                end
            end
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
        start   = 1'b1;
        symbol  = sym;
        last_in = is_last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        absorb_symbol(sym, is_last);
        @(negedge clk);
        if (burst_left == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_symbol(SYM_W'(text[i]), i == text.len() - 1);
    endtask

    task automatic wait_drain();
        start = 1'b0;
        while (pending_cipher_out.size() != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [KEY_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_KEY_COLUMNS)
            key_setting = value;
        else
            decode_setting = value[0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [KEY_W-1:0] key, input logic decode);
        wait_drain();
        write_register(CFG_KEY_COLUMNS, key);
        write_register(CFG_DECODE_MODE, KEY_W'(decode));
    endtask

    function automatic logic [SYM_W-1:0] random_letter();
        return ($urandom_range(0, 1) == 0) ? SYM_W'($urandom_range(65, 90))
                                           : SYM_W'($urandom_range(97, 122));
    endfunction

    function automatic logic [SYM_W-1:0] random_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return random_letter();
        else if (r < 90)
            return SYM_W'($urandom_range(0, 65535));
        else
            return SYM_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return KEY_W'($urandom_range(17, 31));
        else if (r == 2)
            return KEY_W'(KEY_MAX);
        else
            return KEY_W'($urandom_range(1, 8));
    endfunction

    task automatic test_encode_basic();
        configure(5'd3, 1'b0);
        send_symbol("a", 1'b0);
        send_symbol("B", 1'b0);
        send_symbol(16'h0000, 1'b0);
        send_symbol("c", 1'b0);
        send_symbol("d", 1'b0);
        send_symbol(16'hFFFF, 1'b0);
        send_symbol("E", 1'b0);
        send_symbol("@", 1'b0);
        send_symbol("z", 1'b1);
    endtask

    task automatic test_error_cases();
        configure(5'd0, 1'b0);
        send_text("ab");
        configure(5'd17, 1'b0);
        send_text("abcdefghijklmnopqrstuvwxyzabcdefgh");
        configure(5'd2, 1'b0);
        send_text("ab");
        send_text("!");
        configure(5'd2, 1'b1);
        send_text("12345");
    endtask

    task automatic test_mode_sampling();
        configure(5'd1, 1'b0);
        send_symbol("x", 1'b0);
        send_symbol("1", 1'b0);
        wait_drain();
        write_register(CFG_DECODE_MODE, KEY_W'(1));
        send_symbol("1", 1'b0);
        send_symbol("2", 1'b1);
    endtask

    task automatic test_full_grid();
        configure(5'd16, 1'b0);
        for (int i = 0; i < DEF_CAPACITY; i++)
            send_symbol(random_letter(), i == DEF_CAPACITY - 1);
        configure(5'd16, 1'b1);
        for (int i = 0; i < DEF_CAPACITY; i++)
            send_symbol(SYM_W'($urandom_range(0, 65535)), i == DEF_CAPACITY - 1);
    endtask

    task automatic random_message();
        int               target;
        int               first_kept;
        bit               broken;
        logic [SYM_W-1:0] final_sym;
        broken = ($urandom_range(0, 6) == 0);
        if (broken || key_setting == 0 || key_setting > KEY_MAX)
            target = $urandom_range(1, 36);
        else if (decode_setting)
            target = key_setting * $urandom_range(2, DEF_CAPACITY / key_setting);
        else
            target = $urandom_range(2 * key_setting, DEF_CAPACITY);
        first_kept = symbols_kept;
        while (symbols_kept - first_kept < target - 1)
            send_symbol(random_symbol(), 1'b0);
        final_sym = ($urandom_range(0, 9) == 0) ? random_symbol() : random_letter();
        send_symbol(final_sym, 1'b1);
    endtask

    task automatic test_random_messages();
        configure(5'd1, 1'b0);
        random_message();
        configure(5'd16, 1'b1);
        random_message();
        configure(5'd31, 1'b0);
        random_message();
        while (items_sent < 320)
        begin
            if ($urandom_range(0, 2) == 0)
                configure(random_key(), 1'($urandom_range(0, 1)));
            random_message();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        symbol         = '0;
        last_in        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_KEY_COLUMNS;
        cfg_data       = '0;
        text_len       = 0;
        text_overflow  = 0;
        key_setting    = 5'd1;
        decode_setting = 1'b0;
        burst_left     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_encode_basic();
        test_error_cases();
        test_mode_sampling();
        test_full_grid();
        test_random_messages();

        wait_drain();
        repeat (20) @(negedge clk);
        $display("Sent %0d symbols in %0d messages (%0d kept) in both modes, keys 0 to 31.",
                 items_sent, messages_sent, symbols_kept);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
